/* rtl/pfx_pkg.sv */
// Shared types and character codes for the postfix expression evaluator.
`timescale 1ns / 1ps

package pfx_pkg;

    // Width of the value field on the result channel
    localparam int OUT_W = 32;

    // ASCII codes of the characters that carry meaning
    localparam logic [7:0] SYM_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] SYM_NINE  = 8'h39;  // '9'
    localparam logic [7:0] SYM_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] SYM_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] SYM_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] SYM_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] SYM_CARET = 8'h5E;  // '^'

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_ZERO
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_rsp_t;

    typedef struct packed {
        logic ovf;
        logic unf;
        logic opr;
        logic dvz;
    } err_flags_t;

endpackage

/* rtl/pfx_if.sv */
// Valid/ready channel interfaces for expression characters and results.
`timescale 1ns / 1ps

interface pfx_in_if import pfx_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_expression;

    modport source (output valid, symbol, end_of_expression, input ready);
    modport sink   (input valid, symbol, end_of_expression, output ready);
endinterface

interface pfx_out_if import pfx_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] value;
    logic                    overflow_seen;
    logic                    underflow_seen;
    logic                    operator_error_seen;
    logic                    divide_by_zero_seen;

    modport source (output valid, value, overflow_seen, underflow_seen,
                    operator_error_seen, divide_by_zero_seen, input ready);
    modport sink   (input valid, value, overflow_seen, underflow_seen,
                    operator_error_seen, divide_by_zero_seen, output ready);
endinterface

/* rtl/pfx_stack.sv */
// Value stack memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module pfx_stack #(
    parameter int DEPTH = 128,
    parameter int VW    = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [VW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [VW-1:0] rd_data
);

    logic [VW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/pfx_alu.sv */
// Shared arithmetic unit: add, subtract, shift-add multiply, restoring divide, and zero.
`timescale 1ns / 1ps

module pfx_alu import pfx_pkg::*; #(
    parameter int VW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  alu_req_t      req,
    input  logic [VW-1:0] a,
    input  logic [VW-1:0] b,
    output alu_rsp_t      rsp,
    output logic [VW-1:0] result
);

    localparam int CW = $clog2(VW + 1);

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIX
    } alu_state_t;

    alu_state_t    state_reg, state_next;
    logic [VW-1:0] acc_reg, acc_next;
    logic [VW-1:0] mcand_reg, mcand_next;
    logic [VW-1:0] mplier_reg, mplier_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dvsr_reg, dvsr_next;
    logic [VW-1:0] res_reg, res_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          done_reg, done_next;
    logic          dz_reg, dz_next;

    logic [VW-1:0] mul_sum;
    logic [VW:0]   rem_sh;
    logic [VW:0]   rem_diff;

    assign mul_sum  = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign rem_sh   = {rem_reg, quo_reg[VW-1]};
    assign rem_diff = rem_sh - {1'b0, dvsr_reg};

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvsr_next   = dvsr_reg;
        res_next    = res_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        done_next   = 1'b0;
        dz_next     = 1'b0;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    case (req.op)
                        OP_ADD:
                        begin
                            res_next  = a + b;
                            done_next = 1'b1;
                        end
                        OP_SUB:
                        begin
                            res_next  = a - b;
                            done_next = 1'b1;
                        end
                        OP_MUL:
                        begin
                            acc_next    = '0;
                            mcand_next  = a;
                            mplier_next = b;
                            cnt_next    = CW'(VW);
                            state_next  = A_MUL;
                        end
                        OP_DIV:
                        begin
                            neg_next  = a[VW-1] ^ b[VW-1];
                            quo_next  = a[VW-1] ? (~a + 1'b1) : a;
                            dvsr_next = b[VW-1] ? (~b + 1'b1) : b;
                            rem_next  = '0;
                            cnt_next  = CW'(VW);
                            if (b == '0)
                            begin
                                res_next  = '0;
                                dz_next   = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = A_DIV;
                            end
                        end
                        default:
                        begin
                            res_next  = '0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                acc_next    = mul_sum;
                mcand_next  = {mcand_reg[VW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[VW-1:1]};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    res_next   = mul_sum;
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            A_DIV:
            begin
                // one quotient bit per cycle, remainder stays below the divisor
                if (!rem_diff[VW])
                begin
                    rem_next = rem_diff[VW-1:0];
                    quo_next = {quo_reg[VW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[VW-1:0];
                    quo_next = {quo_reg[VW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = A_FIX;
                end
            end
            A_FIX:
            begin
                res_next   = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= A_IDLE;
            acc_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
            dvsr_reg   <= '0;
            res_reg    <= '0;
            cnt_reg    <= '0;
            neg_reg    <= 1'b0;
            done_reg   <= 1'b0;
            dz_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            mcand_reg  <= mcand_next;
            mplier_reg <= mplier_next;
            rem_reg    <= rem_next;
            quo_reg    <= quo_next;
            dvsr_reg   <= dvsr_next;
            res_reg    <= res_next;
            cnt_reg    <= cnt_next;
            neg_reg    <= neg_next;
            done_reg   <= done_next;
            dz_reg     <= dz_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.div_zero = dz_reg;
    assign result       = res_reg;

endmodule

/* rtl/postfix_expression_evaluator.sv */
// Top level of the postfix expression evaluator: sequencer, stack and error flags.
//
// Usage:
//   in_ch carries one expression character per item (symbol) and the
//   end_of_expression mark. Digits push 0..9; + - * / ^ pop right then
//   left operand and push the result (0 for ^); other bytes are ignored.
//   out_ch carries one item per expression: the popped top of stack (0 if
//   empty) and four sticky error flags gathered over that expression.
// Timing:
//   in_ch.ready is high only while the sequencer is idle. A digit passes
//   through decode and push, an ignored byte through decode only, an operator
//   through decode, pops, the shared arithmetic unit (one bit per cycle for
//   * and /, which sets the long cases) and push. End of expression reads the
//   top of stack and loads it into the output register, waiting while it is full.
// Reset:
//   rst_n clears the stack count, flags, output valid and the sequencer. The
//   stack memory itself is not cleared; only entries below the count are read.
// Stalls:
//   The result sits in an output register, so the next characters are taken
//   while it waits. A second result waits in the sequencer until the first
//   is taken.
`timescale 1ns / 1ps

module postfix_expression_evaluator import pfx_pkg::*; #(
    parameter int STACK_DEPTH = 128,
    parameter int VALUE_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    pfx_in_if.sink           in_ch,
    pfx_out_if.source        out_ch
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_R,
        S_POP_L,
        S_GET_L,
        S_EXEC,
        S_WAIT,
        S_PUSH,
        S_END,
        S_FINAL,
        S_FINAL_RD,
        S_EMIT
    } seq_state_t;

    seq_state_t         state_reg, state_next;
    logic [7:0]         sym_reg, sym_next;
    logic               last_reg, last_next;
    logic [CW-1:0]      count_reg, count_next;
    err_flags_t         flags_reg, flags_next;
    logic [VALUE_WIDTH-1:0] l_reg, l_next;
    logic [VALUE_WIDTH-1:0] r_reg, r_next;
    logic [VALUE_WIDTH-1:0] push_reg, push_next;
    alu_op_t            op_reg, op_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_value_reg, out_value_next;
    err_flags_t         out_flags_reg, out_flags_next;

    // stack port controls
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic [CW-1:0]          count_dec;

    alu_req_t               alu_req;
    alu_rsp_t               alu_rsp;
    logic [VALUE_WIDTH-1:0] alu_result;

    pfx_stack #(
        .DEPTH (STACK_DEPTH),
        .VW    (VALUE_WIDTH),
        .AW    (AW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pfx_alu #(
        .VW (VALUE_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (l_reg),
        .b      (r_reg),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    assign count_dec = count_reg - 1'b1;
    assign rd_addr   = count_dec[AW-1:0];
    assign wr_addr   = count_reg[AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        flags_next     = flags_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        push_next      = push_reg;
        op_next        = op_reg;
        out_value_next = out_value_reg;
        out_flags_next = out_flags_reg;
        // drop the result once the receiver takes it
        out_valid_next = out_valid_reg & ~out_ch.ready;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        alu_req.start  = 1'b0;
        alu_req.op     = op_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    sym_next   = in_ch.symbol;
                    last_next  = in_ch.end_of_expression;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sym_reg) inside
                    [SYM_ZERO:SYM_NINE]:
                    begin
                        push_next  = VALUE_WIDTH'(sym_reg - SYM_ZERO);
                        state_next = S_PUSH;
                    end
                    SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH, SYM_CARET:
                    begin
                        case (sym_reg)
                            SYM_PLUS:  op_next = OP_ADD;
                            SYM_MINUS: op_next = OP_SUB;
                            SYM_STAR:  op_next = OP_MUL;
                            SYM_SLASH: op_next = OP_DIV;
                            default:   op_next = OP_ZERO;
                        endcase
                        if (count_reg == '0)
                        begin
                            // operator on an empty stack: flag it, touch nothing
                            flags_next.opr = 1'b1;
                            state_next     = S_END;
                        end
                        else
                        begin
                            state_next = S_POP_R;
                        end
                    end
                    default:
                    begin
                        state_next = S_END;
                    end
                endcase
            end
            S_POP_R:
            begin
                rd_en      = 1'b1;
                count_next = count_dec;
                state_next = S_POP_L;
            end
            S_POP_L:
            begin
                r_next = rd_data;
                if (count_reg == '0)
                begin
                    // left operand missing: use 0 and flag the underflow
                    l_next         = '0;
                    flags_next.unf = 1'b1;
                    state_next     = S_EXEC;
                end
                else
                begin
                    rd_en      = 1'b1;
                    count_next = count_dec;
                    state_next = S_GET_L;
                end
            end
            S_GET_L:
            begin
                l_next     = rd_data;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                alu_req.start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    push_next      = alu_result;
                    flags_next.dvz = flags_reg.dvz | alu_rsp.div_zero;
                    state_next     = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (count_reg == CW'(STACK_DEPTH))
                begin
                    flags_next.ovf = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = S_END;
            end
            S_END:
            begin
                state_next = last_reg ? S_FINAL : S_IDLE;
            end
            S_FINAL:
            begin
                if (count_reg == '0)
                begin
                    l_next         = '0;
                    flags_next.unf = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_FINAL_RD;
                end
            end
            S_FINAL_RD:
            begin
                l_next     = rd_data;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free, then empty the stack
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = OUT_W'(l_reg);
                    out_flags_next = flags_reg;
                    count_next     = '0;
                    flags_next     = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sym_reg       <= '0;
            last_reg      <= 1'b0;
            count_reg     <= '0;
            flags_reg     <= '0;
            l_reg         <= '0;
            r_reg         <= '0;
            push_reg      <= '0;
            op_reg        <= OP_ADD;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_flags_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sym_reg       <= sym_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            flags_reg     <= flags_next;
            l_reg         <= l_next;
            r_reg         <= r_next;
            push_reg      <= push_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_flags_reg <= out_flags_next;
        end
    end

    assign in_ch.ready                = (state_reg == S_IDLE);
    assign out_ch.valid               = out_valid_reg;
    assign out_ch.value               = out_value_reg;
    assign out_ch.overflow_seen       = out_flags_reg.ovf;
    assign out_ch.underflow_seen      = out_flags_reg.unf;
    assign out_ch.operator_error_seen = out_flags_reg.opr;
    assign out_ch.divide_by_zero_seen = out_flags_reg.dvz;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result loaded outside the emit step");

    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && state_next == S_IDLE) |=>
            (count_reg == '0 && flags_reg == '0))
        else $error("stack or flags not cleared after a result");

    a_alu_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> state_reg == S_WAIT)
        else $error("arithmetic result arrived while not waiting");
`endif

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the postfix expression evaluator.
`timescale 1ns / 1ps

module testbench;
    import pfx_pkg::*;

    localparam int STACK_DEPTH = 128;
    localparam int VALUE_WIDTH = 32;
    // Cycles with no item accepted on either channel before the run is abandoned
    localparam int IDLE_LIMIT  = 5000;
    // Longest receiver hold-off, sized so the input channel backs up behind it
    localparam int HOLD_CYCLES = 400;
    // Quiet time after the last result: covers the slowest character (divide)
    localparam int TAIL_CYCLES = 200;
    localparam int ITEMS_PER_PHASE = 200;
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        err_flags_t              flags;
    } result_t;

    logic clk;
    logic rst_n;

    pfx_in_if  in_ch ();
    pfx_out_if out_ch ();

    postfix_expression_evaluator #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Characters waiting to be offered, filled by the stimulus process
    char_item_t pending_chars[$];
    // Scratch buffer for the expression being built
    char_item_t expr_buf[$];
    // Results the evaluator owes us, oldest first
    result_t    expected_results[$];

    // Shadow of the evaluator state, advanced once per accepted character
    logic [31:0] calc_stack [STACK_DEPTH];
    int          calc_depth;
    err_flags_t  calc_flags;

    int errors;
    int meaningful_sent;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_len;
    int idle_cycles;

    // Clock: 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Map a character to its arithmetic operation; return 0 for non-operators.
    function automatic bit decode_op(logic [7:0] sym, output alu_op_t op);
        op = OP_ZERO;
        decode_op = 1'b1;
        case (sym)
            SYM_PLUS:  op = OP_ADD;
            SYM_MINUS: op = OP_SUB;
            SYM_STAR:  op = OP_MUL;
            SYM_SLASH: op = OP_DIV;
            SYM_CARET: op = OP_ZERO;
            default:   decode_op = 1'b0;
        endcase
    endfunction

    function automatic bit is_digit(logic [7:0] sym);
        return sym >= SYM_ZERO && sym <= SYM_NINE;
    endfunction

    function automatic bit is_meaningful(logic [7:0] sym);
        alu_op_t op;
        return is_digit(sym) || decode_op(sym, op);
    endfunction

    // Push with overflow drop
    function automatic void calc_push(logic [31:0] v);
        if (calc_depth >= STACK_DEPTH)
            calc_flags.ovf = 1'b1;
        else
        begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end
    endfunction

    // Pop; an empty stack yields 0 and flags underflow
    function automatic logic [31:0] calc_pop();
        if (calc_depth == 0)
        begin
            calc_flags.unf = 1'b1;
            return '0;
        end
        calc_depth--;
        return calc_stack[calc_depth];
    endfunction

    // 32-bit wrapping arithmetic; division truncates toward zero
    function automatic logic [31:0] calc_apply(alu_op_t op, logic [31:0] lhs,
                                               logic [31:0] rhs);
        case (op)
            OP_ADD: return lhs + rhs;
            OP_SUB: return lhs - rhs;
            OP_MUL: return lhs * rhs;
            OP_DIV:
            begin
                if (rhs == '0)
                begin
                    calc_flags.dvz = 1'b1;
                    return '0;
                end
                // Most negative over minus one wraps back to itself
                if (lhs == MOST_NEG && rhs == '1)
                    return lhs;
                return 32'($signed(lhs) / $signed(rhs));
            end
            default: return '0;
        endcase
    endfunction

    // Advance the shadow state by one character; queue a result on the last one.
    function automatic void eval_char(logic [7:0] sym, logic last);
        alu_op_t     op;
        logic [31:0] lhs;
        logic [31:0] rhs;
        result_t     res;
        if (is_digit(sym))
            calc_push(32'(sym - SYM_ZERO));
        else if (decode_op(sym, op))
        begin
            if (calc_depth == 0)
                calc_flags.opr = 1'b1;
            else
            begin
                rhs = calc_pop();
                lhs = calc_pop();
                calc_push(calc_apply(op, lhs, rhs));
            end
        end
        if (last)
        begin
            // Pop first: an empty stack sets underflow before the flags go out
            res.value = calc_pop();
            res.flags = calc_flags;
            expected_results.push_back(res);
            calc_depth = 0;
            calc_flags = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer pending characters, hold each until accepted
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid             <= 1'b0;
            in_ch.symbol            <= '0;
            in_ch.end_of_expression <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                eval_char(in_ch.symbol, in_ch.end_of_expression);
            // Load a new item only when the slot is free or just drained
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_ch.valid             <= 1'b1;
                    in_ch.symbol            <= pending_chars[0].symbol;
                    in_ch.end_of_expression <= pending_chars[0].last;
                    void'(pending_chars.pop_front());
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, long hold-off, and result checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
                     $signed(want), $signed(got));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual %0d", $time,
                             out_ch.value);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("value", want.value, out_ch.value);
                    check_field("overflow_seen", want.flags.ovf, out_ch.overflow_seen);
                    check_field("underflow_seen", want.flags.unf, out_ch.underflow_seen);
                    check_field("operator_error_seen", want.flags.opr,
                                out_ch.operator_error_seen);
                    check_field("divide_by_zero_seen", want.flags.dvz,
                                out_ch.divide_by_zero_seen);
                end
            end
            // Hold off for the requested stretch, counted here, then resume random stalls
            if (hold_len > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_len <= hold_len - 1;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: give up when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic void add(logic [7:0] sym);
        expr_buf.push_back('{symbol: sym, last: 1'b0});
    endfunction

    function automatic logic [7:0] digit(int n);
        return SYM_ZERO + 8'(n);
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(4))
            0:       return SYM_PLUS;
            1:       return SYM_MINUS;
            2:       return SYM_STAR;
            3:       return SYM_SLASH;
            default: return SYM_CARET;
        endcase
    endfunction

    function automatic logic [7:0] ignored_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (is_meaningful(b));
        return b;
    endfunction

    // Mark the end of the expression and hand it to the driver
    function automatic void commit_expr();
        expr_buf[expr_buf.size() - 1].last = 1'b1;
        foreach (expr_buf[i])
        begin
            if (is_meaningful(expr_buf[i].symbol))
                meaningful_sent++;
            pending_chars.push_back(expr_buf[i]);
        end
        expr_buf.delete();
    endfunction

    // Valid postfix with random digits and operators, sprinkled with ignored bytes
    function automatic void build_wellformed(int operands);
        int depth;
        int left;
        depth = 0;
        left  = operands;
        while (left > 0 || depth > 1)
        begin
            if ($urandom_range(9) == 0)
                add(ignored_byte());
            if (depth >= 2 && (left == 0 || $urandom_range(1) == 1))
            begin
                add(random_operator());
                depth--;
            end
            else
            begin
                add(digit($urandom_range(9)));
                depth++;
                left--;
            end
        end
        // Sometimes end on an ignored byte
        if ($urandom_range(7) == 0)
            add(ignored_byte());
        commit_expr();
    endfunction

    // Broken sequences: arbitrary mix of digits, operators and any byte at all
    function automatic void build_noise(int len);
        repeat (len)
        begin
            case ($urandom_range(2))
                0:       add(digit($urandom_range(9)));
                1:       add(random_operator());
                default: add(8'($urandom_range(255)));
            endcase
        end
        commit_expr();
    endfunction

    // 8^10 * 2 = 2^31, the most negative value, then divide it by -1
    function automatic void build_most_negative();
        add(digit(8));
        repeat (9)
        begin
            add(digit(8));
            add(SYM_STAR);
        end
        add(digit(2));
        add(SYM_STAR);
        add(digit(0));
        add(digit(1));
        add(SYM_MINUS);
        add(SYM_SLASH);
        commit_expr();
    endfunction

    // Fill the stack past its depth so later pushes are dropped
    function automatic void build_overflow();
        repeat (STACK_DEPTH + 1 + $urandom_range(3))
            add(digit($urandom_range(9)));
        if ($urandom_range(1) == 1)
            add(random_operator());
        commit_expr();
    endfunction

    // Random expressions until the phase has sent its share of characters
    task automatic run_random(int count);
        int target;
        int pick;
        target = meaningful_sent + count;
        while (meaningful_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
                build_wellformed($urandom_range(9) == 0 ? $urandom_range(9, 40)
                                                        : $urandom_range(1, 8));
            else if (pick < 93)
                build_noise($urandom_range(1, 12));
            else if (pick < 98)
                build_most_negative();
            else
                build_overflow();
            // Let the driver keep pace so the queue never grows far ahead
            while (pending_chars.size() > 64)
                @(negedge clk);
        end
    endtask

    // Pause the sender until every expected result has come back
    task automatic drain();
        while (pending_chars.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Known values on every input from time zero
        rst_n                   = 1'b0;
        in_ch.valid             = 1'b0;
        in_ch.symbol            = '0;
        in_ch.end_of_expression = 1'b0;
        out_ch.ready            = 1'b0;
        errors                  = 0;
        meaningful_sent         = 0;
        send_idle_pct           = 0;
        recv_stall_pct          = 0;
        hold_len                = 0;
        idle_cycles             = 0;
        calc_depth              = 0;
        calc_flags              = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: byte extremes around a sum, ending on an ignored byte
        add(8'h00);
        add(digit(9));
        add(digit(0));
        add(SYM_PLUS);
        add(8'hFF);
        commit_expr();
        // Operator on an empty stack, then end on the empty stack
        add(SYM_STAR);
        commit_expr();
        // Operator with one entry: left operand underflows to 0
        add(digit(7));
        add(SYM_MINUS);
        commit_expr();
        // Plain division, then division by zero
        add(digit(8));
        add(digit(3));
        add(SYM_SLASH);
        commit_expr();
        add(digit(7));
        add(digit(0));
        add(SYM_SLASH);
        commit_expr();
        add(digit(5));
        add(digit(4));
        add(SYM_STAR);
        commit_expr();
        // Caret pushes 0
        add(digit(3));
        add(digit(4));
        add(SYM_CARET);
        commit_expr();
        // Negative quotient truncates toward zero
        add(digit(0));
        add(digit(7));
        add(SYM_MINUS);
        add(digit(2));
        add(SYM_SLASH);
        commit_expr();
        build_most_negative();
        build_overflow();

        // Phase: no idling on either side
        run_random(ITEMS_PER_PHASE);
        drain();

        // Long receiver hold-off while the sender keeps offering expressions
        hold_len = HOLD_CYCLES;
        repeat (10)
            build_wellformed($urandom_range(1, 3));
        drain();

        // Phase: sender idle about half the time
        send_idle_pct = 52;
        run_random(ITEMS_PER_PHASE);
        drain();

        // Phase: receiver stalling about half the time
        send_idle_pct  = 0;
        recv_stall_pct = 52;
        run_random(ITEMS_PER_PHASE);
        drain();

        // Phase: both sides idle about a third of the time
        send_idle_pct  = 34;
        recv_stall_pct = 34;
        run_random(ITEMS_PER_PHASE);
        drain();

        // Trailing characters may still be in flight; catch any stray result
        repeat (TAIL_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/pfx_pkg.sv
rtl/pfx_if.sv
rtl/pfx_stack.sv
rtl/pfx_alu.sv
rtl/postfix_expression_evaluator.sv
verif/testbench.sv
